@@ hw/rtl/gnz_pkg.sv @@
// ----------------------------------------------------------------------------
// gnz_pkg
// Shared types and constants for the gradient noise block.
// ----------------------------------------------------------------------------
package gnz_pkg;

  localparam int TABLE_SIZE_DEF      = 256;
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH         = 4;

  // request codes on in_req_type
  localparam logic [2:0] REQ_EVAL    = 3'd0;
  localparam logic [2:0] REQ_WR_PERM = 3'd1;
  localparam logic [2:0] REQ_WR_G1   = 3'd2;
  localparam logic [2:0] REQ_WR_G2   = 3'd3;
  localparam logic [2:0] REQ_WR_G3   = 3'd4;

  typedef enum logic [2:0] {
    OP_EVAL,
    OP_WR_PERM,
    OP_WR_G1,
    OP_WR_G2,
    OP_WR_G3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [1:0]         dims;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [7:0]         table_index;
    logic [7:0]         perm_value;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic signed [15:0] grad_z;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

@@ hw/rtl/gnz_front.sv @@
// ----------------------------------------------------------------------------
// gnz_front
// Takes command words, decodes the request type and pushes work to the queue.
// ----------------------------------------------------------------------------
module gnz_front (
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_req_type,
  input  logic [1:0]         in_dimensions,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic [7:0]         in_table_index,
  input  logic [7:0]         in_perm_value,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  input  logic signed [15:0] in_grad_z,
  input  gnz_pkg::q_stat_t   q_stat,
  output logic               push,
  output gnz_pkg::item_t     push_item
);
  import gnz_pkg::*;

  logic known;
  op_t  op;

  always_comb begin
    unique case (in_req_type)
      REQ_EVAL: begin
        op = OP_EVAL; known = 1'b1;
      end
      REQ_WR_PERM: begin
        op = OP_WR_PERM; known = 1'b1;
      end
      REQ_WR_G1: begin
        op = OP_WR_G1; known = 1'b1;
      end
      REQ_WR_G2: begin
        op = OP_WR_G2; known = 1'b1;
      end
      REQ_WR_G3: begin
        op = OP_WR_G3; known = 1'b1;
      end
      default: begin
        op = OP_EVAL; known = 1'b0;
      end
    endcase
  end

  assign busy = q_stat.full;
  // unknown requests are taken and dropped here
  assign push = start && !q_stat.full && known;

  always_comb begin
    push_item.op          = op;
    push_item.dims        = (in_dimensions == 2'd0) ? 2'd1 : in_dimensions;
    push_item.coord_x     = in_coord_x;
    push_item.coord_y     = in_coord_y;
    push_item.coord_z     = in_coord_z;
    push_item.table_index = in_table_index;
    push_item.perm_value  = in_perm_value;
    push_item.grad_x      = in_grad_x;
    push_item.grad_y      = in_grad_y;
    push_item.grad_z      = in_grad_z;
  end

endmodule

@@ hw/rtl/gnz_queue.sv @@
// ----------------------------------------------------------------------------
// gnz_queue
// Short FIFO of decoded words between the front end and the engine.
// ----------------------------------------------------------------------------
module gnz_queue #(
  parameter int DEPTH = gnz_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gnz_pkg::item_t    push_item,
  input  logic              pop,
  output gnz_pkg::item_t    head,
  output gnz_pkg::q_stat_t  q_stat
);
  import gnz_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t           q_mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign q_stat.empty = (count_r == CW'(0));
  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign head         = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + AW'(1);
      if (push && !pop)      count_r <= count_r + CW'(1);
      else if (!push && pop) count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= push_item;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count past depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into full queue");

endmodule

@@ hw/rtl/gnz_engine.sv @@
// ----------------------------------------------------------------------------
// gnz_engine
// Table memories and the sequencer that evaluates noise on one shared multiplier.
// ----------------------------------------------------------------------------
module gnz_engine #(
  parameter int TABLE_SIZE      = gnz_pkg::TABLE_SIZE_DEF,
  parameter int COORD_FRAC_BITS = gnz_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gnz_pkg::q_stat_t   q_stat,
  input  gnz_pkg::item_t     head,
  output logic               q_pop,
  output logic               out_strobe,
  output logic signed [15:0] out_noise_value
);
  import gnz_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CF = COORD_FRAC_BITS;
  localparam int MW = (CF + 4 > 20) ? CF + 4 : 20;
  localparam int PW = 2 * MW;
  localparam int VW = 19;  // corner and blend values stay within +-3*2^15

  localparam logic signed [MW-1:0] CONE    = MW'(64'd1 << CF);
  localparam logic signed [MW-1:0] THREE_C = MW'(64'd3 << CF);
  localparam logic signed [PW-1:0] HALF    = PW'(64'd1 << (CF - 1));
  localparam logic signed [VW-1:0] SMAX    = VW'(32767);
  localparam logic signed [VW-1:0] SMIN    = VW'(-32768);

  typedef enum logic [3:0] {
    S_IDLE, S_CRV_SQ, S_CRV_T2, S_CRV_MUL, S_CRV_S,
    S_PX_RD, S_PX_CAP, S_PXY_RD, S_PXY_CAP,
    S_G_RD, S_DOT_MUL, S_DOT_ADD, S_BL_MUL, S_BL_ADD
  } state_t;

  function automatic logic [IW-1:0] to_idx(input logic [7:0] v);
    logic [IW+7:0] w;
    w = {{IW{1'b0}}, v};
    return w[IW-1:0];
  endfunction

  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v);
    return (v + HALF) >>> CF;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] c;
    c = v;
    if (v > SMAX) c = SMAX;
    else if (v < SMIN) c = SMIN;
    return c[15:0];
  endfunction

  state_t               state_r;
  logic [1:0]           dims_r;
  logic [1:0]           ax_r;
  logic [2:0]           corner_r;
  logic [1:0]           term_r;
  logic [1:0]           lvl_r;
  logic [CF-1:0]        t_r   [3];
  logic [IW-1:0]        b0_r  [3];
  logic signed [MW-1:0] s_r   [3];
  logic [7:0]           px_r  [2];
  logic [7:0]           pxy_r [4];
  logic signed [MW-1:0] t2_r;
  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] acc_r;
  logic signed [VW-1:0] xa_r, ya_r, za_r, bl_a_r, bl_b_r;
  logic                 out_strobe_r;
  logic signed [15:0]   out_value_r;

  // table memories
  logic [7:0]           perm_mem [TABLE_SIZE];
  logic [15:0]          g1_mem   [TABLE_SIZE];
  logic [31:0]          g2_mem   [TABLE_SIZE];
  logic [47:0]          g3_mem   [TABLE_SIZE];
  logic [7:0]           perm_rd_r;
  logic [15:0]          g1_rd_r;
  logic [31:0]          g2_rd_r;
  logic [47:0]          g3_rd_r;

  logic                 perm_we, g1_we, g2_we, g3_we, perm_re, g_re;
  logic [IW-1:0]        wr_idx, perm_ra, g_ra;
  logic [IW-1:0]        bsel [3];
  logic signed [MW-1:0] rsel [3];
  logic signed [31:0]   crd  [3];
  logic signed [31:0]   crd_sh [3];
  logic [15:0]          gsel;
  logic signed [MW-1:0] t_ext, mul_a, mul_b;
  logic signed [PW-1:0] mul_p, rnd_p, dot_full;
  logic signed [VW-1:0] dot_v, bl_diff, bl_v;
  logic                 last_term, last_lvl, pend_bit;

  assign q_pop  = (state_r == S_IDLE) && !q_stat.empty;
  assign wr_idx = to_idx(head.table_index);
  assign perm_we = q_pop && (head.op == OP_WR_PERM);
  assign g1_we   = q_pop && (head.op == OP_WR_G1);
  assign g2_we   = q_pop && (head.op == OP_WR_G2);
  assign g3_we   = q_pop && (head.op == OP_WR_G3);
  assign perm_re = (state_r == S_PX_RD) || (state_r == S_PXY_RD);
  assign g_re    = (state_r == S_G_RD);

  assign crd[0] = head.coord_x;
  assign crd[1] = head.coord_y;
  assign crd[2] = head.coord_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      crd_sh[k] = crd[k] >>> CF;  // floor of the cell coordinate
      bsel[k]   = b0_r[k] + IW'(corner_r[k]);
      rsel[k]   = $signed({{(MW-CF){1'b0}}, t_r[k]}) - (corner_r[k] ? CONE : '0);
    end
  end

  // hash addresses
  always_comb begin
    perm_ra = (state_r == S_PX_RD) ? bsel[0] : to_idx(px_r[corner_r[0]]) + bsel[1];
    unique case (dims_r)
      2'd2:    g_ra = to_idx(pxy_r[corner_r[1:0]]);
      2'd3:    g_ra = to_idx(pxy_r[corner_r[1:0]]) + bsel[2];
      default: g_ra = to_idx(px_r[corner_r[0]]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (perm_we) perm_mem[wr_idx] <= head.perm_value;
    if (perm_re) perm_rd_r <= perm_mem[perm_ra];
  end

  always_ff @(posedge clk) begin
    if (g1_we) g1_mem[wr_idx] <= head.grad_x;
    if (g_re)  g1_rd_r <= g1_mem[g_ra];
  end

  always_ff @(posedge clk) begin
    if (g2_we) g2_mem[wr_idx] <= {head.grad_y, head.grad_x};
    if (g_re)  g2_rd_r <= g2_mem[g_ra];
  end

  always_ff @(posedge clk) begin
    if (g3_we) g3_mem[wr_idx] <= {head.grad_z, head.grad_y, head.grad_x};
    if (g_re)  g3_rd_r <= g3_mem[g_ra];
  end

  // gradient component for the current term
  always_comb begin
    if (dims_r == 2'd3) begin
      unique case (term_r)
        2'd1:    gsel = g3_rd_r[31:16];
        2'd2:    gsel = g3_rd_r[47:32];
        default: gsel = g3_rd_r[15:0];
      endcase
    end else if (dims_r == 2'd2) begin
      gsel = term_r[0] ? g2_rd_r[31:16] : g2_rd_r[15:0];
    end else begin
      gsel = g1_rd_r;
    end
  end

  assign t_ext   = $signed({{(MW-CF){1'b0}}, t_r[ax_r]});
  assign bl_diff = bl_b_r - bl_a_r;

  always_comb begin
    unique case (state_r)
      S_CRV_SQ: begin
        mul_a = t_ext; mul_b = t_ext;
      end
      S_CRV_MUL: begin
        mul_a = t2_r; mul_b = THREE_C - (t_ext <<< 1);
      end
      S_DOT_MUL: begin
        mul_a = rsel[term_r];
        mul_b = $signed({{(MW-16){gsel[15]}}, gsel});
      end
      S_BL_MUL: begin
        mul_a = s_r[lvl_r];
        mul_b = $signed({{(MW-VW){bl_diff[VW-1]}}, bl_diff});
      end
      default: begin
        mul_a = '0; mul_b = '0;
      end
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  assign rnd_p     = rnd(prod_r);
  assign dot_full  = rnd(acc_r + prod_r);
  assign dot_v     = dot_full[VW-1:0];
  assign bl_v      = bl_a_r + $signed(rnd_p[VW-1:0]);
  assign last_term = (term_r == 2'(dims_r - 2'd1));
  assign last_lvl  = (lvl_r == 2'(dims_r - 2'd1));
  assign pend_bit  = (lvl_r == 2'd0) ? corner_r[1] : corner_r[2];

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_pop && head.op == OP_EVAL) begin
            dims_r <= head.dims;
            for (int k = 0; k < 3; k++) begin
              t_r[k]  <= crd[k][CF-1:0];
              b0_r[k] <= crd_sh[k][IW-1:0];
            end
            ax_r    <= '0;
            state_r <= S_CRV_SQ;
          end
        end
        S_CRV_SQ:  state_r <= S_CRV_T2;
        S_CRV_T2: begin
          t2_r    <= rnd_p[MW-1:0];
          state_r <= S_CRV_MUL;
        end
        S_CRV_MUL: state_r <= S_CRV_S;
        S_CRV_S: begin
          s_r[ax_r] <= rnd_p[MW-1:0];
          if (ax_r == 2'(dims_r - 2'd1)) begin
            corner_r <= '0;
            state_r  <= S_PX_RD;
          end else begin
            ax_r    <= ax_r + 2'd1;
            state_r <= S_CRV_SQ;
          end
        end
        S_PX_RD:   state_r <= S_PX_CAP;
        S_PX_CAP: begin
          px_r[corner_r[0]] <= perm_rd_r;
          if (corner_r[0]) begin
            corner_r <= '0;
            state_r  <= (dims_r == 2'd1) ? S_G_RD : S_PXY_RD;
          end else begin
            corner_r <= corner_r + 3'd1;
            state_r  <= S_PX_RD;
          end
        end
        S_PXY_RD:  state_r <= S_PXY_CAP;
        S_PXY_CAP: begin
          pxy_r[corner_r[1:0]] <= perm_rd_r;
          if (corner_r[1:0] == 2'd3) begin
            corner_r <= '0;
            state_r  <= S_G_RD;
          end else begin
            corner_r <= corner_r + 3'd1;
            state_r  <= S_PXY_RD;
          end
        end
        S_G_RD: begin
          acc_r   <= '0;
          term_r  <= '0;
          state_r <= S_DOT_MUL;
        end
        S_DOT_MUL: state_r <= S_DOT_ADD;
        S_DOT_ADD: begin
          if (last_term) begin
            if (!corner_r[0]) begin
              xa_r     <= dot_v;
              corner_r <= corner_r + 3'd1;
              state_r  <= S_G_RD;
            end else begin
              bl_a_r  <= xa_r;
              bl_b_r  <= dot_v;
              lvl_r   <= '0;
              state_r <= S_BL_MUL;
            end
          end else begin
            acc_r   <= acc_r + prod_r;
            term_r  <= term_r + 2'd1;
            state_r <= S_DOT_MUL;
          end
        end
        S_BL_MUL:  state_r <= S_BL_ADD;
        S_BL_ADD: begin
          priority if (last_lvl) begin
            out_strobe_r <= 1'b1;
            out_value_r  <= sat16(bl_v);
            state_r      <= S_IDLE;
          end else if (!pend_bit) begin
            // first half of the pair at this level: park it
            if (lvl_r == 2'd0) ya_r <= bl_v;
            else               za_r <= bl_v;
            corner_r <= corner_r + 3'd1;
            state_r  <= S_G_RD;
          end else begin
            bl_a_r  <= (lvl_r == 2'd0) ? ya_r : za_r;
            bl_b_r  <= bl_v;
            lvl_r   <= lvl_r + 2'd1;
            state_r <= S_BL_MUL;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_noise_value = out_value_r;

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == S_BL_ADD))
    else $error("result strobe without final blend");

  a_dims_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (dims_r != 2'd0))
    else $error("evaluate running with zero dimensions");

  a_eval_start: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && head.op == OP_EVAL) |=> (state_r == S_CRV_SQ))
    else $error("evaluate word popped but not started");

endmodule

@@ hw/rtl/gradient_noise_1d_2d_3d.sv @@
// ----------------------------------------------------------------------------
// gradient_noise_1d_2d_3d
// Classic lattice gradient noise in 1, 2 or 3 dimensions, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word is taken on a rising edge with start high and
//   busy low. in_req_type selects evaluate or one of four table writes;
//   unknown types are taken and dropped. Words pass a 4-deep queue to the
//   engine, so busy only rises when the queue is full.
//   Result channel: out_strobe is high for one cycle with out_noise_value;
//   there is no back-pressure, each result is taken when shown.
//   Engine: a table write is done as its word is popped; evaluate time grows
//   with the dimension count, set by the single shared multiplier and the
//   one read port per table (up to 6 permutation reads, 8 gradient reads).
//   Result appears in the cycle after the engine finishes; results leave in
//   the order their words were taken.
//   Reset (rst_n low, synchronous) empties the queue and idles the engine.
//   Table contents are not cleared: load every entry before reading it.
// ----------------------------------------------------------------------------
module gradient_noise_1d_2d_3d #(
  parameter int TABLE_SIZE      = gnz_pkg::TABLE_SIZE_DEF,
  parameter int COORD_FRAC_BITS = gnz_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_req_type,
  input  logic [1:0]         in_dimensions,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic [7:0]         in_table_index,
  input  logic [7:0]         in_perm_value,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  input  logic signed [15:0] in_grad_z,
  output logic               out_strobe,
  output logic signed [15:0] out_noise_value
);
  import gnz_pkg::*;

  logic    push, pop;
  item_t   push_item, head;
  q_stat_t q_stat;

  gnz_front u_front (
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_dimensions  (in_dimensions),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .in_table_index (in_table_index),
    .in_perm_value  (in_perm_value),
    .in_grad_x      (in_grad_x),
    .in_grad_y      (in_grad_y),
    .in_grad_z      (in_grad_z),
    .q_stat         (q_stat),
    .push           (push),
    .push_item      (push_item)
  );

  gnz_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  gnz_engine #(
    .TABLE_SIZE      (TABLE_SIZE),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .head            (head),
    .q_pop           (pop),
    .out_strobe      (out_strobe),
    .out_noise_value (out_noise_value)
  );

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for the gradient noise block: loads every table entry, then runs
// directed and random evaluate words mixed with table rewrites and unknown
// request types. Each result is checked against a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;
  import gnz_pkg::*;

  localparam int LIMIT = 1000000;

  typedef struct {
    logic [2:0]         req;
    logic [1:0]         dims;
    logic signed [31:0] cx, cy, cz;
    logic [7:0]         idx, pval;
    logic signed [15:0] gx, gy, gz;
    bit                 drain;
  } word_t;

  logic clk = 0, rst_n = 0, start = 0;
  logic busy, out_strobe;
  logic [2:0] in_req_type = 0;
  logic [1:0] in_dimensions = 0;
  logic signed [31:0] in_coord_x = 0, in_coord_y = 0, in_coord_z = 0;
  logic [7:0] in_table_index = 0, in_perm_value = 0;
  logic signed [15:0] in_grad_x = 0, in_grad_y = 0, in_grad_z = 0;
  logic signed [15:0] out_noise_value;

  gradient_noise_1d_2d_3d uut (.*);

  initial forever #4 clk = ~clk;

  // predictor tables
  logic [7:0]         perm_tab [256];
  logic signed [15:0] g1_tab [256];
  logic signed [15:0] g2x_tab [256], g2y_tab [256];
  logic signed [15:0] g3x_tab [256], g3y_tab [256], g3z_tab [256];

  word_t              pending [$];
  logic signed [15:0] noise_exp [$];
  int  fails = 0;
  int  cycles = 0;
  int  gap_left = 0;

  function automatic longint rnd_sh(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint blend(longint s, longint a, longint b);
    return a + rnd_sh(s * (b - a));
  endfunction

  function automatic void split_axis(input logic [31:0] c, output int b0, output int b1,
                                     output longint r0, output longint r1, output longint s);
    longint t, t2;
    t  = c[15:0];
    b0 = c[23:16];
    b1 = (b0 + 1) & 255;
    r0 = t;
    r1 = t - 65536;
    t2 = (t * t + 32768) >> 16;
    s  = (t2 * (3 * 65536 - 2 * t) + 32768) >> 16;
  endfunction

  function automatic longint dot2(int h, longint rx, longint ry);
    return rnd_sh(rx * g2x_tab[h & 255] + ry * g2y_tab[h & 255]);
  endfunction

  function automatic longint dot3(int h, longint rx, longint ry, longint rz);
    return rnd_sh(rx * g3x_tab[h & 255] + ry * g3y_tab[h & 255] + rz * g3z_tab[h & 255]);
  endfunction

  function automatic logic signed [15:0] noise_of(word_t w);
    int xb0, xb1, yb0, yb1, zb0, zb1, i, j, b00, b10, b01, b11;
    longint xr0, xr1, xs, yr0, yr1, ys, zr0, zr1, zs, u, v, a, b, c, d, r;
    split_axis(w.cx, xb0, xb1, xr0, xr1, xs);
    if (w.dims <= 1) begin
      u = rnd_sh(xr0 * g1_tab[perm_tab[xb0]]);
      v = rnd_sh(xr1 * g1_tab[perm_tab[xb1]]);
      r = blend(xs, u, v);
    end else begin
      split_axis(w.cy, yb0, yb1, yr0, yr1, ys);
      i = perm_tab[xb0];
      j = perm_tab[xb1];
      b00 = perm_tab[(i + yb0) & 255];
      b10 = perm_tab[(j + yb0) & 255];
      b01 = perm_tab[(i + yb1) & 255];
      b11 = perm_tab[(j + yb1) & 255];
      if (w.dims == 2) begin
        a = blend(xs, dot2(b00, xr0, yr0), dot2(b10, xr1, yr0));
        b = blend(xs, dot2(b01, xr0, yr1), dot2(b11, xr1, yr1));
        r = blend(ys, a, b);
      end else begin
        split_axis(w.cz, zb0, zb1, zr0, zr1, zs);
        a = blend(xs, dot3(b00 + zb0, xr0, yr0, zr0), dot3(b10 + zb0, xr1, yr0, zr0));
        b = blend(xs, dot3(b01 + zb0, xr0, yr1, zr0), dot3(b11 + zb0, xr1, yr1, zr0));
        c = blend(ys, a, b);
        a = blend(xs, dot3(b00 + zb1, xr0, yr0, zr1), dot3(b10 + zb1, xr1, yr0, zr1));
        b = blend(xs, dot3(b01 + zb1, xr0, yr1, zr1), dot3(b11 + zb1, xr1, yr1, zr1));
        d = blend(ys, a, b);
        r = blend(zs, c, d);
      end
    end
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic void apply_word(word_t w);
    case (w.req)
      REQ_EVAL:    noise_exp.push_back(noise_of(w));
      REQ_WR_PERM: perm_tab[w.idx] = w.pval;
      REQ_WR_G1:   g1_tab[w.idx] = w.gx;
      REQ_WR_G2: begin
        g2x_tab[w.idx] = w.gx;
        g2y_tab[w.idx] = w.gy;
      end
      REQ_WR_G3: begin
        g3x_tab[w.idx] = w.gx;
        g3y_tab[w.idx] = w.gy;
        g3z_tab[w.idx] = w.gz;
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  function automatic logic signed [15:0] rnd_grad();
    return 16'($urandom_range(32768) - 16384);
  endfunction

  function automatic word_t rnd_word(logic [2:0] req);
    word_t w;
    w.req = req;
    w.dims = 2'($urandom);
    w.cx = $urandom;
    w.cy = $urandom;
    w.cz = $urandom;
    w.idx = 8'($urandom);
    w.pval = 8'($urandom);
    w.gx = rnd_grad();
    w.gy = rnd_grad();
    w.gz = rnd_grad();
    w.drain = 0;
    return w;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
    end else begin
      cycles++;
      if (start && !busy) begin
        apply_word(pending[0]);
        pending.pop_front();
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 0;
        end else if (pending.size() != 0 && !(pending[0].drain && noise_exp.size() != 0)) begin
          start <= 1;
          in_req_type <= pending[0].req;
          in_dimensions <= pending[0].dims;
          in_coord_x <= pending[0].cx;
          in_coord_y <= pending[0].cy;
          in_coord_z <= pending[0].cz;
          in_table_index <= pending[0].idx;
          in_perm_value <= pending[0].pval;
          in_grad_x <= pending[0].gx;
          in_grad_y <= pending[0].gy;
          in_grad_z <= pending[0].gz;
          gap_left = pick_gap();
        end else begin
          start <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (noise_exp.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, out_noise_value);
        fails++;
      end else begin
        if (out_noise_value !== noise_exp[0]) begin
          $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                   $time, noise_exp[0], out_noise_value);
          fails++;
        end
        noise_exp.pop_front();
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    word_t w;
    logic signed [31:0] edge_c [6];
    int r;
    edge_c = '{32'sh0, 32'sh7fffffff, 32'sh80000000, -32'sd1, 32'sh0000ffff, 32'sh00008000};
    // load every entry of every table; extreme gradients on a few entries
    for (int k = 0; k < 256; k++) begin
      for (int t = 1; t <= 4; t++) begin
        w = rnd_word(t[2:0]);
        w.idx = 8'(k);
        if (k < 2) begin
          w.gx = k ? 16'sd16384 : -16'sd16384;
          w.gy = w.gx;
          w.gz = w.gx;
          w.pval = k ? 8'hff : 8'h00;
        end
        pending.push_back(w);
      end
    end
    // directed evaluates: coordinate extremes in every dimension count
    for (int k = 0; k < 6; k++) begin
      for (int d = 0; d < 4; d++) begin
        if (k >= 4 && d == 0) continue;
        w = rnd_word(REQ_EVAL);
        w.dims = 2'(d);
        w.cx = edge_c[k];
        w.cy = edge_c[(k + 1) % 6];
        w.cz = edge_c[(k + 2) % 6];
        pending.push_back(w);
      end
    end
    w = rnd_word(3'd5);
    pending.push_back(w);
    w = rnd_word(3'd7);
    pending.push_back(w);
    for (int k = 0; k < 75; k++) begin
      r = $urandom_range(99);
      if (r < 70) w = rnd_word(REQ_EVAL);
      else if (r < 94) w = rnd_word(3'($urandom_range(4, 1)));
      else w = rnd_word(3'($urandom_range(7, 5)));
      w.drain = (k == 37);
      pending.push_back(w);
    end
    repeat (3) @(posedge clk);
    rst_n <= 1;
    wait (pending.size() == 0 && !start && noise_exp.size() == 0);
    repeat (200) @(posedge clk);
    if (fails == 0 && noise_exp.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
